>>> sv/rrwl_pkg.sv
// Shared types and constants for the recursive reader-writer lock manager.
// No dependencies; imported by every module of the block.
package rrwl_pkg;

    localparam int THREADS_DEF    = 16;
    localparam int COUNT_BITS_DEF = 8;
    localparam int CMD_W          = 2;
    localparam int TID_W          = 4;
    localparam int STATUS_W       = 3;
    localparam int MODE_W         = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_READ   = 2'd0,
        CMD_WRITE  = 2'd1,
        CMD_UNLOCK = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_GRANTED    = 3'd0,
        STAT_WAIT       = 3'd1,
        STAT_DEADLOCK   = 3'd2,
        STAT_NOT_HOLDER = 3'd3,
        STAT_OVERFLOW   = 3'd4
    } status_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_FREE  = 2'd0,
        MODE_READ  = 2'd1,
        MODE_WRITE = 2'd2
    } mode_t;

    typedef enum logic {
        ST_IDLE,
        ST_DECIDE
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;  // latch request, start count lookup
        logic commit;   // decide, update lock state, load result
    } dp_cmd_t;

endpackage

>>> sv/rrwl_ctrl.sv
// Sequencer for the lock manager: request acceptance, decide step, result valid.
// Depends on rrwl_pkg.
module rrwl_ctrl
    import rrwl_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    req_valid,
    output logic    req_stall,
    output logic    rsp_valid,
    input  logic    rsp_stall,
    output dp_cmd_t dp_cmd
);

    ctrl_state_t state_reg, state_next;
    logic        rsp_valid_reg, rsp_valid_next;
    logic        can_load;

    // result register free, or being emptied this cycle
    assign can_load = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (can_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        req_stall      = 1'b1;
        dp_cmd.capture = 1'b0;
        dp_cmd.commit  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_stall      = 1'b0;
                dp_cmd.capture = req_valid;
            end
            ST_DECIDE:
            begin
                dp_cmd.commit = can_load;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        if (dp_cmd.commit)
        begin
            rsp_valid_next = 1'b1;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg && rsp_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

>>> sv/rrwl_datapath.sv
// Lock state, per-thread hold-count memory, decision logic and result register.
// Depends on rrwl_pkg; driven by rrwl_ctrl through dp_cmd_t.
module rrwl_datapath
    import rrwl_pkg::*;
#(
    parameter int THREADS    = THREADS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  dp_cmd_t             dp_cmd,
    input  logic [CMD_W-1:0]    command,
    input  logic [TID_W-1:0]    thread_id,
    output logic [STATUS_W-1:0] status,
    output logic                wake_all,
    output logic [MODE_W-1:0]   lock_mode
);

    localparam int IW = (THREADS > 1) ? $clog2(THREADS) : 1;
    localparam int HW = $clog2(THREADS + 1);
    localparam int EW = IW + TID_W;

    // hold counts; an entry never written reads as zero via its valid bit
    logic [COUNT_BITS-1:0] cnt_mem [THREADS];
    logic [THREADS-1:0]    cnt_valid_reg;
    logic [COUNT_BITS-1:0] cnt_rd_reg;

    logic [THREADS-1:0]    upg_reg;
    logic [THREADS-1:0]    wait_reg;
    logic [HW-1:0]         wait_cnt_reg, wait_cnt_next;
    logic [HW-1:0]         holder_reg, holder_next;
    logic                  pend_reg, pend_next;
    mode_t                 mode_reg, mode_next;

    logic [CMD_W-1:0]      cmd_reg;
    logic [TID_W-1:0]      tid_reg;

    logic [STATUS_W-1:0]   status_reg;
    logic                  wake_reg;
    logic [MODE_W-1:0]     lock_mode_reg;

    logic [EW-1:0]         in_ext, tid_ext;
    logic [IW-1:0]         in_idx, idx;
    logic                  in_range;
    logic [COUNT_BITS-1:0] cnt, cnt_inc, cnt_dec;
    logic                  cnt_zero, cnt_full;
    logic                  is_upg, is_wait, others_wait;
    logic [HW-1:0]         wait_left;

    status_t               st;
    logic                  wake;
    logic                  cnt_we;
    logic [COUNT_BITS-1:0] cnt_wval;
    logic                  upg_we, upg_wval;
    logic                  wait_we, wait_wval;

    assign in_ext   = {{IW{1'b0}}, thread_id};
    assign in_idx   = in_ext[IW-1:0];
    assign tid_ext  = {{IW{1'b0}}, tid_reg};
    assign idx      = tid_ext[IW-1:0];
    assign in_range = tid_ext < EW'(THREADS);

    assign cnt         = cnt_valid_reg[idx] ? cnt_rd_reg : '0;
    assign cnt_inc     = cnt + COUNT_BITS'(1);
    assign cnt_dec     = cnt - COUNT_BITS'(1);
    assign cnt_zero    = (cnt == '0);
    assign cnt_full    = &cnt;
    assign is_upg      = upg_reg[idx];
    assign is_wait     = wait_reg[idx];
    assign others_wait = wait_cnt_reg > HW'(is_wait);
    assign wait_left   = wait_cnt_reg - HW'(is_wait);

    always_comb
    begin
        st          = STAT_NOT_HOLDER;
        wake        = 1'b0;
        mode_next   = mode_reg;
        holder_next = holder_reg;
        pend_next   = pend_reg;
        cnt_we      = 1'b0;
        cnt_wval    = cnt_inc;
        upg_we      = 1'b0;
        upg_wval    = 1'b0;
        wait_we     = 1'b0;
        wait_wval   = 1'b0;

        if (in_range)
        begin
            unique case (cmd_reg)
                CMD_READ:
                begin
                    if (mode_reg == MODE_FREE)
                    begin
                        st          = STAT_GRANTED;
                        cnt_we      = 1'b1;
                        cnt_wval    = COUNT_BITS'(1);
                        holder_next = HW'(1);
                        mode_next   = MODE_READ;
                    end
                    else if (!cnt_zero)
                    begin
                        if (cnt_full)
                        begin
                            st = STAT_OVERFLOW;
                        end
                        else
                        begin
                            st     = STAT_GRANTED;
                            cnt_we = 1'b1;
                        end
                    end
                    else if (mode_reg == MODE_WRITE || others_wait)
                    begin
                        st = STAT_WAIT;
                    end
                    else
                    begin
                        st          = STAT_GRANTED;
                        cnt_we      = 1'b1;
                        cnt_wval    = COUNT_BITS'(1);
                        holder_next = holder_reg + HW'(1);
                    end
                    wait_we   = 1'b1;
                    wait_wval = (st == STAT_WAIT);
                end
                CMD_WRITE:
                begin
                    if (mode_reg == MODE_FREE)
                    begin
                        st          = STAT_GRANTED;
                        cnt_we      = 1'b1;
                        cnt_wval    = COUNT_BITS'(1);
                        holder_next = HW'(1);
                        mode_next   = MODE_WRITE;
                    end
                    else if (cnt_zero)
                    begin
                        st = STAT_WAIT;
                    end
                    else if (mode_reg == MODE_WRITE)
                    begin
                        if (cnt_full)
                        begin
                            st = STAT_OVERFLOW;
                        end
                        else
                        begin
                            st     = STAT_GRANTED;
                            cnt_we = 1'b1;
                        end
                    end
                    else if (holder_reg == HW'(1))
                    begin
                        // sole reader: upgrade at once
                        upg_we    = 1'b1;
                        upg_wval  = 1'b0;
                        pend_next = 1'b0;
                        if (cnt_full)
                        begin
                            st = STAT_OVERFLOW;
                        end
                        else
                        begin
                            st        = STAT_GRANTED;
                            cnt_we    = 1'b1;
                            mode_next = MODE_WRITE;
                        end
                    end
                    else if (is_upg)
                    begin
                        st = STAT_WAIT;
                    end
                    else if (pend_reg)
                    begin
                        st = STAT_DEADLOCK;
                    end
                    else
                    begin
                        st        = STAT_WAIT;
                        upg_we    = 1'b1;
                        upg_wval  = 1'b1;
                        pend_next = 1'b1;
                    end
                    wait_we   = 1'b1;
                    wait_wval = (st == STAT_WAIT);
                end
                CMD_UNLOCK:
                begin
                    if (mode_reg != MODE_FREE && !cnt_zero)
                    begin
                        st       = STAT_GRANTED;
                        cnt_we   = 1'b1;
                        cnt_wval = cnt_dec;
                        if (cnt_dec == '0)
                        begin
                            // last hold of this thread: drop its marks
                            if (is_upg)
                            begin
                                upg_we    = 1'b1;
                                upg_wval  = 1'b0;
                                pend_next = 1'b0;
                            end
                            wait_we   = 1'b1;
                            wait_wval = 1'b0;
                            if (holder_reg != '0)
                            begin
                                holder_next = holder_reg - HW'(1);
                            end
                            if (holder_next == '0)
                            begin
                                mode_next = MODE_FREE;
                                wake      = (wait_left != '0);
                            end
                            else
                            begin
                                wake = pend_next && (holder_next == HW'(1));
                            end
                        end
                    end
                end
                default:
                begin
                    st = STAT_NOT_HOLDER;
                end
            endcase
        end
    end

    always_comb
    begin
        wait_cnt_next = wait_cnt_reg;
        if (wait_we && wait_wval && !is_wait)
        begin
            wait_cnt_next = wait_cnt_reg + HW'(1);
        end
        else if (wait_we && !wait_wval && is_wait)
        begin
            wait_cnt_next = wait_cnt_reg - HW'(1);
        end
    end

    // count memory: one read at capture, one write at commit
    always_ff @(posedge clk)
    begin
        if (dp_cmd.capture)
        begin
            cnt_rd_reg <= cnt_mem[in_idx];
        end
        if (dp_cmd.commit && cnt_we)
        begin
            cnt_mem[idx] <= cnt_wval;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.capture)
        begin
            cmd_reg <= command;
            tid_reg <= thread_id;
        end
        if (dp_cmd.commit)
        begin
            status_reg    <= st;
            wake_reg      <= wake;
            lock_mode_reg <= mode_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_valid_reg <= '0;
            upg_reg       <= '0;
            wait_reg      <= '0;
            wait_cnt_reg  <= '0;
            holder_reg    <= '0;
            pend_reg      <= 1'b0;
            mode_reg      <= MODE_FREE;
        end
        else if (dp_cmd.commit)
        begin
            if (cnt_we)
            begin
                cnt_valid_reg[idx] <= 1'b1;
            end
            if (upg_we)
            begin
                upg_reg[idx] <= upg_wval;
            end
            if (wait_we)
            begin
                wait_reg[idx] <= wait_wval;
            end
            wait_cnt_reg <= wait_cnt_next;
            holder_reg   <= holder_next;
            pend_reg     <= pend_next;
            mode_reg     <= mode_next;
        end
    end

    assign status    = status_reg;
    assign wake_all  = wake_reg;
    assign lock_mode = lock_mode_reg;

endmodule

>>> sv/recursive_rw_lock_manager.sv
// Reader-writer lock manager with recursive holds and read-to-write upgrade.
// Top level; instantiates rrwl_ctrl and rrwl_datapath, depends on rrwl_pkg.
//
// Each request (command, thread_id) gets exactly one answer (status,
// wake_all, lock_mode). A request is handled in two steps: the first reads the
// thread's hold count from the count memory, the second decides, writes the
// lock state back and loads the result register; no new request is taken
// until the last one is decided. The decide step holds while an earlier result still
// waits in the result register. No clearing pass: count entries carry
// valid bits cleared by reset, and the lock is usable as soon as reset ends.
module recursive_rw_lock_manager
    import rrwl_pkg::*;
#(
    parameter int THREADS    = THREADS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  logic [CMD_W-1:0]    command,
    input  logic [TID_W-1:0]    thread_id,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output logic [STATUS_W-1:0] status,
    output logic                wake_all,
    output logic [MODE_W-1:0]   lock_mode
);

    dp_cmd_t dp_cmd;

    rrwl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .dp_cmd    (dp_cmd)
    );

    rrwl_datapath #(
        .THREADS    (THREADS),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .dp_cmd    (dp_cmd),
        .command   (command),
        .thread_id (thread_id),
        .status    (status),
        .wake_all  (wake_all),
        .lock_mode (lock_mode)
    );

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for recursive_rw_lock_manager: directed, overflow,
// backpressure and random lock traffic, checked against an in-bench lock model.
// Depends on rrwl_pkg and the recursive_rw_lock_manager RTL.
module tb_top;
    import rrwl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
    localparam int HOLD_MAX     = (1 << COUNT_BITS_DEF) - 1;
    localparam int RANDOM_ITEMS = 900;

    typedef struct {
        status_t st;
        logic    wake;
        mode_t   md;
    } lock_answer_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                req_valid;
    logic                req_stall;
    logic [CMD_W-1:0]    command;
    logic [TID_W-1:0]    thread_id;
    logic                rsp_valid;
    logic                rsp_stall;
    logic [STATUS_W-1:0] status;
    logic                wake_all;
    logic [MODE_W-1:0]   lock_mode;

    // lock model state
    mode_t                     lk_mode = MODE_FREE;
    logic [COUNT_BITS_DEF-1:0] hold_cnt [THREADS_DEF] = '{default: '0};
    bit                        upg_mark [THREADS_DEF] = '{default: 1'b0};
    bit                        wait_mark [THREADS_DEF] = '{default: 1'b0};
    bit                        upg_pending = 1'b0;
    int                        holder_cnt = 0;

    lock_answer_t pending_answers [$];

    bit no_idle   = 1'b0;
    bit sink_hold = 1'b0;
    int mismatches = 0;
    int requests_sent = 0;
    int results_checked = 0;
    int wake_hits = 0;
    int status_hits [5] = '{default: 0};

    recursive_rw_lock_manager uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .command   (command),
        .thread_id (thread_id),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .status    (status),
        .wake_all  (wake_all),
        .lock_mode (lock_mode)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    function automatic status_t bump_hold(input int t);
        if (hold_cnt[t] == HOLD_MAX)
            return STAT_OVERFLOW;
        hold_cnt[t]++;
        return STAT_GRANTED;
    endfunction

    // Applies one request to the lock model and returns the answer it gives.
    function automatic lock_answer_t decide_request(input logic [CMD_W-1:0] cmd, input int t);
        lock_answer_t ans;
        bit others;
        ans.st   = STAT_NOT_HOLDER;
        ans.wake = 1'b0;
        others   = 1'b0;
        foreach (wait_mark[i])
            if (i != t && wait_mark[i])
                others = 1'b1;
        case (cmd)
            CMD_READ, CMD_WRITE:
            begin
                if (lk_mode == MODE_FREE)
                begin
                    hold_cnt[t] = 1;
                    holder_cnt  = 1;
                    lk_mode     = (cmd == CMD_READ) ? MODE_READ : MODE_WRITE;
                    ans.st      = STAT_GRANTED;
                end
                else if (hold_cnt[t] != 0 && (lk_mode == MODE_WRITE || cmd == CMD_READ))
                begin
                    ans.st = bump_hold(t);
                end
                else if (hold_cnt[t] == 0)
                begin
                    // newcomer; readers give way to anyone already waiting
                    if (cmd == CMD_WRITE || lk_mode == MODE_WRITE || others)
                        ans.st = STAT_WAIT;
                    else
                    begin
                        hold_cnt[t] = 1;
                        holder_cnt++;
                        ans.st = STAT_GRANTED;
                    end
                end
                else if (holder_cnt == 1)
                begin
                    // sole reader upgrades at once
                    ans.st = bump_hold(t);
                    if (ans.st == STAT_GRANTED)
                        lk_mode = MODE_WRITE;
                    upg_mark[t] = 1'b0;
                    upg_pending = 1'b0;
                end
                else if (upg_mark[t])
                    ans.st = STAT_WAIT;
                else if (upg_pending)
                    ans.st = STAT_DEADLOCK;
                else
                begin
                    upg_mark[t] = 1'b1;
                    upg_pending = 1'b1;
                    ans.st      = STAT_WAIT;
                end
                wait_mark[t] = (ans.st == STAT_WAIT);
            end
            CMD_UNLOCK:
            begin
                if (lk_mode != MODE_FREE && hold_cnt[t] != 0)
                begin
                    hold_cnt[t]--;
                    ans.st = STAT_GRANTED;
                    if (hold_cnt[t] == 0)
                    begin
                        // last hold gone: any upgrade of this thread is abandoned
                        if (upg_mark[t])
                        begin
                            upg_mark[t] = 1'b0;
                            upg_pending = 1'b0;
                        end
                        wait_mark[t] = 1'b0;
                        if (holder_cnt != 0)
                            holder_cnt--;
                        if (holder_cnt == 0)
                        begin
                            lk_mode  = MODE_FREE;
                            ans.wake = others;
                        end
                        else if (upg_pending && holder_cnt == 1)
                            ans.wake = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        ans.md = lk_mode;
        return ans;
    endfunction

    // Offers one request and predicts its answer on the transfer. Starts and ends
    // at a falling edge with valid left high, so back-to-back calls need no gap.
    task automatic send_req(input logic [CMD_W-1:0] cmd, input logic [TID_W-1:0] tid);
        int gap;
        lock_answer_t ans;
        gap = no_idle ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        command   <= cmd;
        thread_id <= tid;
        do @(posedge clk); while (req_stall !== 1'b0);
        ans = decide_request(cmd, int'(tid));
        pending_answers.insert(pending_answers.size(), ans);
        status_hits[ans.st]++;
        if (ans.wake)
            wake_hits++;
        requests_sent++;
        @(negedge clk);
    endtask

    function automatic logic [CMD_W-1:0] pick_command();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            return CMD_READ;
        if (roll < 65)
            return CMD_WRITE;
        return CMD_UNLOCK;
    endfunction

    task automatic test_directed_cases();
        send_req(CMD_UNLOCK, 0);    // unlock of a free lock
        send_req(CMD_SPARE, 1);     // unused command
        send_req(CMD_READ, 0);
        send_req(CMD_READ, 0);      // read re-entry
        send_req(CMD_READ, 1);      // second reader joins
        send_req(CMD_WRITE, 2);     // writer waits on readers
        send_req(CMD_READ, 3);      // new reader held back by the waiting writer
        send_req(CMD_WRITE, 0);     // upgrade request with another reader present
        send_req(CMD_WRITE, 1);     // competing upgrade: deadlock
        send_req(CMD_WRITE, 0);     // still waiting to upgrade
        send_req(CMD_UNLOCK, 1);    // one holder left with upgrade pending: wake
        send_req(CMD_WRITE, 0);     // sole reader upgrade
        send_req(CMD_READ, 0);      // read re-entry in write mode
        send_req(CMD_WRITE, 0);     // write re-entry
        send_req(CMD_READ, 2);      // reader blocked by the writer
        send_req(CMD_UNLOCK, 15);   // unlock by a non-holder
        repeat (5) send_req(CMD_UNLOCK, 0);
        send_req(CMD_WRITE, 15);
        send_req(CMD_UNLOCK, 15);   // release with waiters still marked
        send_req(CMD_SPARE, 15);
    endtask

    task automatic test_count_overflow();
        no_idle = 1'b1;
        repeat (HOLD_MAX) send_req(CMD_READ, 5);
        send_req(CMD_READ, 5);      // read count saturates
        send_req(CMD_WRITE, 5);     // upgrade would overflow
        send_req(CMD_UNLOCK, 5);
        send_req(CMD_WRITE, 5);     // upgrade lands on the top count
        send_req(CMD_WRITE, 5);     // write re-entry overflow
        send_req(CMD_READ, 5);      // read in write mode overflow
        repeat (HOLD_MAX) send_req(CMD_UNLOCK, 5);
        no_idle = 1'b0;
    endtask

    // Result side holds off long enough for the block to fill and stall requests.
    task automatic test_backpressure();
        no_idle = 1'b1;
        fork
            begin
                @(posedge clk);
                sink_hold = 1'b1;
                repeat (300) @(posedge clk);
                sink_hold = 1'b0;
            end
            begin
                repeat (40) send_req(pick_command(), TID_W'($urandom_range(0, 3)));
                req_valid <= 1'b0;
            end
        join
        @(negedge clk);
        no_idle = 1'b0;
    endtask

    // Bursts of traffic from a small pool of threads so that contention, upgrades
    // and deadlocks occur often; some noise from any thread and any command.
    task automatic test_random_traffic();
        int sent;
        int burst;
        int pool_size;
        logic [TID_W-1:0] pool [4];
        logic [TID_W-1:0] tid;
        logic [CMD_W-1:0] cmd;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            pool_size = $urandom_range(2, 4);
            foreach (pool[i])
                pool[i] = TID_W'($urandom_range(0, THREADS_DEF - 1));
            burst   = $urandom_range(10, 50);
            no_idle = ($urandom_range(0, 3) == 0);
            repeat (burst)
            begin
                if ($urandom_range(0, 99) < 12)
                begin
                    cmd = CMD_W'($urandom_range(0, 3));
                    tid = TID_W'($urandom_range(0, THREADS_DEF - 1));
                end
                else
                begin
                    cmd = pick_command();
                    tid = pool[$urandom_range(0, pool_size - 1)];
                end
                send_req(cmd, tid);
                sent++;
            end
            // half the time release everything so the next burst starts from free
            if ($urandom_range(0, 1))
                for (int t = 0; t < THREADS_DEF; t++)
                    while (hold_cnt[t] != 0)
                    begin
                        send_req(CMD_UNLOCK, TID_W'(t));
                        sent++;
                    end
        end
        no_idle = 1'b0;
    endtask

    // result sink: random stall after every transfer, plus the long hold-off
    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        rsp_stall  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_valid === 1'b1 && rsp_stall === 1'b0)
                stall_left = no_idle ? 0 : $urandom_range(0, 16);
            @(negedge clk);
            rsp_stall <= (sink_hold || stall_left > 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    always @(posedge clk)
    begin : result_check
        lock_answer_t exp;
        if (rst_n === 1'b1 && rsp_valid === 1'b1 && rsp_stall === 1'b0)
        begin
            results_checked++;
            if (pending_answers.size() == 0)
                report_mismatch($sformatf("result with no request outstanding (status %0d)",
                                          status));
            else
            begin
                exp = pending_answers.pop_front();
                if (status !== exp.st)
                    report_mismatch($sformatf("status %0d, expected %0d", status, exp.st));
                if (wake_all !== exp.wake)
                    report_mismatch($sformatf("wake_all %0b, expected %0b", wake_all, exp.wake));
                if (lock_mode !== exp.md)
                    report_mismatch($sformatf("lock_mode %0d, expected %0d", lock_mode, exp.md));
            end
        end
    end

    initial
    begin : main_seq
        rst_n     = 1'b0;
        req_valid = 1'b0;
        command   = CMD_READ;
        thread_id = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed_cases();
        test_count_overflow();
        test_backpressure();
        test_random_traffic();
        req_valid <= 1'b0;
        wait (pending_answers.size() == 0);
        repeat (20) @(posedge clk);
        $display("Covered %0d requests: %0d granted, %0d wait, %0d deadlock, %0d not holder, %0d overflow",
                 requests_sent, status_hits[STAT_GRANTED], status_hits[STAT_WAIT],
                 status_hits[STAT_DEADLOCK], status_hits[STAT_NOT_HOLDER],
                 status_hits[STAT_OVERFLOW]);
        $display("%0d answers raised wake_all; %0d results checked, %0d mismatches",
                 wake_hits, results_checked, mismatches);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("timeout with %0d results outstanding", pending_answers.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
